// ===== design/vtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vtsc_pkg : shared types and constants of the valve timing setpoint coordinator
// Register indexes, arithmetic constants and the structs that pass between the
// configuration bank, the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package vtsc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SWEEP_LIMIT_ENABLE   = 3'd0;
    localparam logic [2:0] REG_INTAKE_PRESENT       = 3'd1;
    localparam logic [2:0] REG_EXHAUST_PRESENT      = 3'd2;
    localparam logic [2:0] REG_INTAKE_BENCH_ENABLE  = 3'd3;
    localparam logic [2:0] REG_INTAKE_BENCH_ANGLE   = 3'd4;
    localparam logic [2:0] REG_EXHAUST_BENCH_ENABLE = 3'd5;
    localparam logic [2:0] REG_EXHAUST_BENCH_ANGLE  = 3'd6;
    localparam logic [2:0] REG_RAMP_STEP            = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Arithmetic constants
    localparam logic [7:0]  OFFSET_FLIP   = 8'h80;       // signed to offset binary
    localparam logic [7:0]  BENCH_RESET   = 8'd128;
    localparam logic [9:0]  RATIO_FULL    = 10'd1000;
    localparam int          RATIO_SCALE   = 13107;
    localparam int          STEP_SCALE    = 200;
    localparam int          RATIO_HALF    = 6553;
    localparam int          BLEND_HALF    = 500;
    // 13107 * 5 = 65535 = 2^16 - 1, so the ramp quotient reduces to a /(2^16-1)
    localparam int          SCALE_TO_MERSENNE = 5;
    localparam int          MERSENNE_SHIFT    = 16;
    localparam logic [27:0] MERSENNE_DIV      = 28'd65535;
    // Reciprocal of 1000: ceil(2^28 / 1000), exact for sums below 2^18
    localparam logic [18:0] BLEND_RECIP   = 19'd268436;
    localparam int          BLEND_SHIFT   = 28;

    localparam int VTSC_QUEUE_DEPTH = 4;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        sweep_limit_enable;
        logic        intake_present;
        logic        exhaust_present;
        logic        intake_bench_enable;
        logic [7:0]  intake_bench_angle;
        logic        exhaust_bench_enable;
        logic [7:0]  exhaust_bench_angle;
        logic [9:0]  ramp_quot;   // round(step*200/13107)
        logic [23:0] ramp_span;   // step*200
    } cfg_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic [7:0] in_lim;
        logic [7:0] ex_lim;
        logic [7:0] in_bench_val;
        logic [7:0] ex_bench_val;
        logic [7:0] in_park;
        logic [7:0] ex_park;
        logic       ramp_up;
        logic       loop_cmd;
        logic [7:0] loop_ref;
    } item_t;

endpackage

`default_nettype wire

// ===== design/vtsc_cfg.sv =====
// ----------------------------------------------------------------------------
// vtsc_cfg : configuration register bank
// Holds the written registers and derives the ramp step terms from ramp_step.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsc_cfg
    import vtsc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_enable,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    logic        sweep_limit_enable_reg;
    logic        intake_present_reg;
    logic        exhaust_present_reg;
    logic        intake_bench_enable_reg;
    logic [7:0]  intake_bench_angle_reg;
    logic        exhaust_bench_enable_reg;
    logic [7:0]  exhaust_bench_angle_reg;
    logic [15:0] ramp_step_reg;
    logic [9:0]  ramp_quot_reg;
    logic [9:0]  ramp_quot_next;
    logic [23:0] ramp_span_reg;
    logic [23:0] ramp_span_next;

    logic [23:0] step_rounded;
    logic [26:0] step_times5;
    logic [27:0] folded;
    logic [11:0] quot_est;
    logic [27:0] quot_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_limit_enable_reg   <= 1'b0;
            intake_present_reg       <= 1'b1;
            exhaust_present_reg      <= 1'b1;
            intake_bench_enable_reg  <= 1'b0;
            intake_bench_angle_reg   <= BENCH_RESET;
            exhaust_bench_enable_reg <= 1'b0;
            exhaust_bench_angle_reg  <= BENCH_RESET;
            ramp_step_reg            <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_SWEEP_LIMIT_ENABLE:   sweep_limit_enable_reg   <= cfg_data[0];
                REG_INTAKE_PRESENT:       intake_present_reg       <= cfg_data[0];
                REG_EXHAUST_PRESENT:      exhaust_present_reg      <= cfg_data[0];
                REG_INTAKE_BENCH_ENABLE:  intake_bench_enable_reg  <= cfg_data[0];
                REG_INTAKE_BENCH_ANGLE:   intake_bench_angle_reg   <= cfg_data[7:0];
                REG_EXHAUST_BENCH_ENABLE: exhaust_bench_enable_reg <= cfg_data[0];
                REG_EXHAUST_BENCH_ANGLE:  exhaust_bench_angle_reg  <= cfg_data[7:0];
                REG_RAMP_STEP:            ramp_step_reg            <= cfg_data[15:0];
            endcase
        end
    end

    // Ramp quotient floor((step*200 + 6553) / 13107) as floor(5x / (2^16-1)):
    // fold the high half in, then correct the estimate by at most one.
    always_comb
    begin
        ramp_span_next = 24'(ramp_step_reg) * 24'(STEP_SCALE);
        step_rounded   = ramp_span_next + 24'(RATIO_HALF);
        step_times5    = 27'(step_rounded) * 27'(SCALE_TO_MERSENNE);
        folded         = 28'(step_times5) + 28'(step_times5[26:MERSENNE_SHIFT]);
        quot_est       = folded[27:MERSENNE_SHIFT];
        quot_rem       = 28'(step_times5) - {quot_est, 16'b0} + 28'(quot_est);
        if (quot_rem >= MERSENNE_DIV)
        begin
            ramp_quot_next = 10'(quot_est + 12'd1);
        end
        else
        begin
            ramp_quot_next = quot_est[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_quot_reg <= '0;
            ramp_span_reg <= '0;
        end
        else
        begin
            ramp_quot_reg <= ramp_quot_next;
            ramp_span_reg <= ramp_span_next;
        end
    end

    always_comb
    begin
        cfg.sweep_limit_enable   = sweep_limit_enable_reg;
        cfg.intake_present       = intake_present_reg;
        cfg.exhaust_present      = exhaust_present_reg;
        cfg.intake_bench_enable  = intake_bench_enable_reg;
        cfg.intake_bench_angle   = intake_bench_angle_reg;
        cfg.exhaust_bench_enable = exhaust_bench_enable_reg;
        cfg.exhaust_bench_angle  = exhaust_bench_angle_reg;
        cfg.ramp_quot            = ramp_quot_reg;
        cfg.ramp_span            = ramp_span_reg;
    end

endmodule

`default_nettype wire

// ===== design/vtsc_front.sv =====
// ----------------------------------------------------------------------------
// vtsc_front : input stage
// Accepts a tick, applies offset, limits and bench selection, and classifies
// the ramp direction; holds the result until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsc_front
    import vtsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  intake_request,
    input  wire logic [7:0]  exhaust_request,
    input  wire logic [7:0]  intake_minimum,
    input  wire logic [7:0]  exhaust_maximum,
    input  wire logic [7:0]  intake_park_max,
    input  wire logic [7:0]  exhaust_park_min,
    input  wire logic        intake_servo_active,
    input  wire logic        exhaust_servo_active,
    input  wire logic        intake_loop_command,
    input  wire logic [7:0]  intake_loop_reference,
    output logic             push_valid,
    output item_t            push_item,
    input  wire logic        queue_full
);

    logic  front_valid_reg;
    item_t front_item_reg;
    item_t item_next;
    logic [7:0] in_raw;
    logic [7:0] ex_raw;

    always_comb
    begin
        in_raw = intake_request ^ OFFSET_FLIP;
        ex_raw = exhaust_request ^ OFFSET_FLIP;

        item_next.in_lim = (cfg.sweep_limit_enable && (in_raw < intake_minimum))
                           ? intake_minimum : in_raw;
        item_next.ex_lim = (cfg.sweep_limit_enable && (ex_raw > exhaust_maximum))
                           ? exhaust_maximum : ex_raw;
        item_next.in_bench_val = cfg.intake_bench_enable ? cfg.intake_bench_angle
                                                         : item_next.in_lim;
        item_next.ex_bench_val = cfg.exhaust_bench_enable ? cfg.exhaust_bench_angle
                                                          : item_next.ex_lim;
        item_next.in_park  = intake_park_max;
        item_next.ex_park  = exhaust_park_min;
        // an absent servo counts as active
        item_next.ramp_up  = (!cfg.intake_present || intake_servo_active)
                          && (!cfg.exhaust_present || exhaust_servo_active);
        item_next.loop_cmd = intake_loop_command;
        item_next.loop_ref = intake_loop_reference ^ OFFSET_FLIP;
    end

    assign in_ready   = !front_valid_reg || !queue_full;
    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            front_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/vtsc_queue.sv =====
// ----------------------------------------------------------------------------
// vtsc_queue : item queue between front and back end
// Small circular buffer; the head is presented for the back end to pop.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsc_queue
    import vtsc_pkg::*;
#(
    parameter int DEPTH = VTSC_QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/vtsc_back.sv =====
// ----------------------------------------------------------------------------
// vtsc_back : execution pipeline
// Ramps the transition ratio, blends bench and park setpoints, divides by the
// full ratio and selects the intake loop setpoint into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsc_back
    import vtsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  head_valid,
    input  wire item_t head_item,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] intake_limited,
    output logic [7:0] exhaust_limited,
    output logic [7:0] intake_after_bench,
    output logic [7:0] exhaust_after_bench,
    output logic [9:0] transition_ratio,
    output logic [7:0] intake_blended,
    output logic [7:0] exhaust_blended,
    output logic [7:0] intake_loop_setpoint
);

    typedef struct packed {
        logic [9:0] ratio;
        logic [7:0] in_lim;
        logic [7:0] ex_lim;
        logic [7:0] in_bench;
        logic [7:0] ex_bench;
        logic [7:0] in_park;
        logic [7:0] ex_park;
        logic       loop_cmd;
        logic [7:0] loop_ref;
    } ramp_stage_t;

    typedef struct packed {
        logic [9:0]  ratio;
        logic [7:0]  in_lim;
        logic [7:0]  ex_lim;
        logic [7:0]  in_bench;
        logic [7:0]  ex_bench;
        logic [17:0] in_sum;
        logic [17:0] ex_sum;
        logic        loop_cmd;
        logic [7:0]  loop_ref;
    } blend_stage_t;

    logic         advance;
    logic         ramp_valid_reg;
    logic         blend_valid_reg;
    logic         out_valid_reg;
    ramp_stage_t  ramp_stage_reg;
    blend_stage_t blend_stage_reg;

    logic [9:0]  ratio_reg;
    logic [9:0]  ratio_next;
    logic [7:0]  intake_bench_reg;
    logic [7:0]  intake_bench_next;
    logic [7:0]  exhaust_bench_reg;
    logic [7:0]  exhaust_bench_next;
    logic [7:0]  intake_blend_reg;
    logic [7:0]  exhaust_blend_reg;
    logic [7:0]  intake_loop_reg;

    logic [7:0]  in_lim_reg;
    logic [7:0]  ex_lim_reg;
    logic [7:0]  in_after_reg;
    logic [7:0]  ex_after_reg;
    logic [9:0]  ratio_out_reg;

    logic [23:0] ratio_scaled;
    logic [10:0] ratio_up_sum;
    logic [9:0]  ratio_up;
    logic [9:0]  ratio_down;
    logic [7:0]  in_quot;
    logic [7:0]  ex_quot;

    // park*1000 + r*(bench - park) + 500, equal to r*bench + (1000-r)*park + 500
    function automatic logic [17:0] blend_sum(input logic [9:0] r,
                                              input logic [7:0] bench,
                                              input logic [7:0] park);
        logic signed [8:0]  diff;
        logic signed [19:0] prod;
        logic [17:0]        base;
        logic signed [19:0] total;
        diff  = $signed({1'b0, bench}) - $signed({1'b0, park});
        prod  = $signed({1'b0, r}) * diff;
        base  = 18'(park) * 18'(RATIO_FULL) + 18'(BLEND_HALF);
        total = $signed({2'b00, base}) + prod;
        return total[17:0];
    endfunction

    // divide by 1000 through the reciprocal
    function automatic logic [7:0] blend_quot(input logic [17:0] s);
        logic [36:0] prod;
        prod = 37'(s) * 37'(BLEND_RECIP);
        return prod[BLEND_SHIFT +: 8];
    endfunction

    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && head_valid;

    // Ratio ramp: up by the step quotient, clamped; down by it, or to zero once
    // the scaled ratio falls below the step span.
    always_comb
    begin
        ratio_scaled = 24'(ratio_reg) * 24'(RATIO_SCALE);
        ratio_up_sum = {1'b0, ratio_reg} + {1'b0, cfg.ramp_quot};
        ratio_up     = (ratio_up_sum > {1'b0, RATIO_FULL}) ? RATIO_FULL : ratio_up_sum[9:0];
        ratio_down   = (ratio_scaled < cfg.ramp_span) ? '0 : ratio_reg - cfg.ramp_quot;
        ratio_next   = head_item.ramp_up ? ratio_up : ratio_down;

        intake_bench_next  = cfg.intake_present  ? head_item.in_bench_val : intake_bench_reg;
        exhaust_bench_next = cfg.exhaust_present ? head_item.ex_bench_val : exhaust_bench_reg;

        in_quot = blend_quot(blend_stage_reg.in_sum);
        ex_quot = blend_quot(blend_stage_reg.ex_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_valid_reg    <= 1'b0;
            blend_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            ratio_reg         <= '0;
            intake_bench_reg  <= '0;
            exhaust_bench_reg <= '0;
            intake_blend_reg  <= '0;
            exhaust_blend_reg <= '0;
            intake_loop_reg   <= '0;
        end
        else if (advance)
        begin
            ramp_valid_reg  <= head_valid;
            blend_valid_reg <= ramp_valid_reg;
            out_valid_reg   <= blend_valid_reg;
            if (head_valid)
            begin
                ratio_reg         <= ratio_next;
                intake_bench_reg  <= intake_bench_next;
                exhaust_bench_reg <= exhaust_bench_next;
            end
            if (blend_valid_reg && cfg.intake_present)
            begin
                intake_blend_reg <= in_quot;
                intake_loop_reg  <= blend_stage_reg.loop_cmd ? in_quot
                                                             : blend_stage_reg.loop_ref;
            end
            if (blend_valid_reg && cfg.exhaust_present)
            begin
                exhaust_blend_reg <= ex_quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (head_valid)
            begin
                ramp_stage_reg.ratio    <= ratio_next;
                ramp_stage_reg.in_lim   <= head_item.in_lim;
                ramp_stage_reg.ex_lim   <= head_item.ex_lim;
                ramp_stage_reg.in_bench <= intake_bench_next;
                ramp_stage_reg.ex_bench <= exhaust_bench_next;
                ramp_stage_reg.in_park  <= head_item.in_park;
                ramp_stage_reg.ex_park  <= head_item.ex_park;
                ramp_stage_reg.loop_cmd <= head_item.loop_cmd;
                ramp_stage_reg.loop_ref <= head_item.loop_ref;
            end
            if (ramp_valid_reg)
            begin
                blend_stage_reg.ratio    <= ramp_stage_reg.ratio;
                blend_stage_reg.in_lim   <= ramp_stage_reg.in_lim;
                blend_stage_reg.ex_lim   <= ramp_stage_reg.ex_lim;
                blend_stage_reg.in_bench <= ramp_stage_reg.in_bench;
                blend_stage_reg.ex_bench <= ramp_stage_reg.ex_bench;
                blend_stage_reg.in_sum   <= blend_sum(ramp_stage_reg.ratio,
                                                      ramp_stage_reg.in_bench,
                                                      ramp_stage_reg.in_park);
                blend_stage_reg.ex_sum   <= blend_sum(ramp_stage_reg.ratio,
                                                      ramp_stage_reg.ex_bench,
                                                      ramp_stage_reg.ex_park);
                blend_stage_reg.loop_cmd <= ramp_stage_reg.loop_cmd;
                blend_stage_reg.loop_ref <= ramp_stage_reg.loop_ref;
            end
            if (blend_valid_reg)
            begin
                in_lim_reg    <= blend_stage_reg.in_lim;
                ex_lim_reg    <= blend_stage_reg.ex_lim;
                in_after_reg  <= blend_stage_reg.in_bench;
                ex_after_reg  <= blend_stage_reg.ex_bench;
                ratio_out_reg <= blend_stage_reg.ratio;
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign intake_limited       = in_lim_reg;
    assign exhaust_limited      = ex_lim_reg;
    assign intake_after_bench   = in_after_reg;
    assign exhaust_after_bench  = ex_after_reg;
    assign transition_ratio     = ratio_out_reg;
    assign intake_blended       = intake_blend_reg;
    assign exhaust_blended      = exhaust_blend_reg;
    assign intake_loop_setpoint = intake_loop_reg;

endmodule

`default_nettype wire

// ===== design/valve_timing_setpoint_coordinator_core.sv =====
// ----------------------------------------------------------------------------
// valve_timing_setpoint_coordinator_core : cam setpoint coordinator
// One control tick in, one set of limited, benched, ramped and blended
// setpoints out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one control tick per transfer;
//   output channel out_valid/out_ready carries one result per tick, in order.
//   Registers are written through cfg_write_enable/cfg_index/cfg_data with no
//   handshake; write them only while no tick is in flight.
//   A transferred tick passes the front register, the queue, the ramp stage,
//   the blend stage and the output register before it gives out_valid.
//   Throughput: one tick per cycle while the receiver keeps up, set by the
//   ratio update in the ramp stage, which feeds the next tick's ramp.
//   Reset clears the ratio and the bench, blend and loop setpoints, loads the
//   register defaults (both servos present, bench angles 128), empties the queue.
//   When the receiver stalls, the back end holds; the queue then fills and
//   in_ready falls once the front register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module valve_timing_setpoint_coordinator_core
    import vtsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = VTSC_QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_write_enable,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             intake_request,
    input  wire logic [7:0]             exhaust_request,
    input  wire logic [7:0]             intake_minimum,
    input  wire logic [7:0]             exhaust_maximum,
    input  wire logic [7:0]             intake_park_max,
    input  wire logic [7:0]             exhaust_park_min,
    input  wire logic                   intake_servo_active,
    input  wire logic                   exhaust_servo_active,
    input  wire logic                   intake_loop_command,
    input  wire logic [7:0]             intake_loop_reference,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  intake_limited,
    output logic [7:0]                  exhaust_limited,
    output logic [7:0]                  intake_after_bench,
    output logic [7:0]                  exhaust_after_bench,
    output logic [9:0]                  transition_ratio,
    output logic [7:0]                  intake_blended,
    output logic [7:0]                  exhaust_blended,
    output logic [7:0]                  intake_loop_setpoint
);

    cfg_t  cfg;
    logic  push_valid;
    item_t push_item;
    logic  queue_full;
    logic  head_valid;
    item_t head_item;
    logic  pop;

    // Register bank and derived ramp terms
    vtsc_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg)
    );

    // Front end: offset, limit, bench select, ramp direction
    vtsc_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg                   (cfg),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .intake_request        (intake_request),
        .exhaust_request       (exhaust_request),
        .intake_minimum        (intake_minimum),
        .exhaust_maximum       (exhaust_maximum),
        .intake_park_max       (intake_park_max),
        .exhaust_park_min      (exhaust_park_min),
        .intake_servo_active   (intake_servo_active),
        .exhaust_servo_active  (exhaust_servo_active),
        .intake_loop_command   (intake_loop_command),
        .intake_loop_reference (intake_loop_reference),
        .push_valid            (push_valid),
        .push_item             (push_item),
        .queue_full            (queue_full)
    );

    // Decouple front and back so each can stall on its own
    vtsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: ratio ramp, blend, divide, loop select and held outputs
    vtsc_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .head_valid           (head_valid),
        .head_item            (head_item),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .intake_limited       (intake_limited),
        .exhaust_limited      (exhaust_limited),
        .intake_after_bench   (intake_after_bench),
        .exhaust_after_bench  (exhaust_after_bench),
        .transition_ratio     (transition_ratio),
        .intake_blended       (intake_blended),
        .exhaust_blended      (exhaust_blended),
        .intake_loop_setpoint (intake_loop_setpoint)
    );

    // The ramp clamp keeps the ratio within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (transition_ratio <= RATIO_FULL))
        else $error("transition ratio above full scale");

    // A held front item with a full queue must stop the input channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && queue_full) |-> !in_ready)
        else $error("input taken while front item blocked");

    // Bench override reaches the output unchanged for a present intake servo
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg.intake_present && cfg.intake_bench_enable)
            |-> (intake_after_bench == cfg.intake_bench_angle))
        else $error("intake bench override lost");

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
